FILE: rtl/bfha_pkg.sv
// Shared types and constants for the best-fit heap allocator.
// No dependencies; imported by best_fit_heap_allocator_top.
package bfha_pkg;

   localparam int unsigned ADDR_BITS   = 20;
   localparam int unsigned SIZE_BITS   = 21;
   localparam int unsigned SPLIT_SLACK = 4;

   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_FIT   = 2'd1,
      ST_BAD_ADDR = 2'd2
   } status_type;

   typedef enum logic [6:0] {
      S_INIT  = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_SCAN  = 7'b0000100,
      S_SHIFT = 7'b0001000,
      S_WR_A  = 7'b0010000,
      S_WR_B  = 7'b0100000,
      S_DONE  = 7'b1000000
   } fsm_type;

endpackage

FILE: rtl/best_fit_heap_allocator_top.sv
// Best-fit heap allocator with block coalescing, built around one block table memory.
// Depends on bfha_pkg for the state encoding, request kinds and status codes.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | req_type, req_size, req_free_addr,
//           |           |                        | req_null_pointer
//   rsp     | out       | rsp_valid / rsp_stall  | rsp_status, rsp_payload_addr
//
// One request is processed at a time. A request is accepted, then the table is scanned
// with one read of the single table port per entry, the read pipeline is drained and the
// result is decided. An allocate writes its entry; a split allocate first shifts up to
// block_count - 1 entries up one place and also writes the free remainder. A free writes
// the merged entry, then shifts the tail down over any absorbed neighbours. The result
// then goes to the output register. A null free skips the scan and answers directly.
// After reset, the S_INIT state writes the initial free block into entry 0; requests stall then.
// A pending result waits in the output register while the next request is already accepted.
module best_fit_heap_allocator_top #(
   parameter int unsigned HEAP_BYTES   = 1048576,
   parameter int unsigned HEADER_BYTES = 12,
   parameter int unsigned MAX_BLOCKS   = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_type,
   input  logic [bfha_pkg::SIZE_BITS-1:0]       req_size,
   input  logic [bfha_pkg::ADDR_BITS-1:0]       req_free_addr,
   input  logic                                 req_null_pointer,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_status,
   output logic [bfha_pkg::ADDR_BITS-1:0]       rsp_payload_addr
);
   import bfha_pkg::*;

   // Offsets and sizes need enough bits for the whole heap.
   localparam int unsigned W  = $clog2(HEAP_BYTES) + 1;
   // Wide enough for offset + header and for the 21-bit request size.
   localparam int unsigned SW = (W + 1 > SIZE_BITS) ? W + 1 : SIZE_BITS;
   localparam int unsigned XW = SW + 1;
   localparam int unsigned IW = $clog2(MAX_BLOCKS);
   localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);

   typedef struct packed {
      logic [W-1:0] start;
      logic [W-1:0] size;
      logic         free;
   } entry_type;

   // Block table, kept in address order.
   entry_type mem [MAX_BLOCKS];
   entry_type mem_q;
   logic          mem_re, mem_we;
   logic [IW-1:0] mem_ra, mem_wa;
   entry_type     mem_wd;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         mem_q <= mem[mem_ra];
      end
   end

   fsm_type          state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             op_free_ff, op_free_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic [ADDR_BITS-1:0] faddr_ff, faddr_in;
   // Read pipeline shared by the scan and the shift.
   logic [CW-1:0]    issue_ff, issue_in;
   logic             p_valid_ff, p_valid_in;
   logic [CW-1:0]    p_idx_ff, p_idx_in;
   // Scan results.
   logic             found_ff, found_in;
   logic [CW-1:0]    hit_ff, hit_in;
   entry_type        hit_ent_ff, hit_ent_in;
   entry_type        prev_ff, prev_in;
   entry_type        next_ff, next_in;
   entry_type        last_ff, last_in;
   logic             has_prev_ff, has_prev_in;
   logic             has_next_ff, has_next_in;
   logic             split_ff, split_in;
   logic             pf_ff, pf_in;
   logic             nf_ff, nf_in;
   // Shift engine.
   logic             sh_up_ff, sh_up_in;
   logic [1:0]       sh_d_ff, sh_d_in;
   logic [CW-1:0]    sh_rd_ff, sh_rd_in;
   logic [CW-1:0]    sh_left_ff, sh_left_in;
   // Result.
   status_type       res_st_ff, res_st_in;
   logic [ADDR_BITS-1:0] res_addr_ff, res_addr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [ADDR_BITS-1:0] rsp_addr_ff, rsp_addr_in;

   logic             fit, better, match, scan_end, split_cond;
   logic [SW-1:0]    match_sum, best_pay;
   logic [W-1:0]     tot_k;
   logic             nf_w, pf_w;

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_payload_addr = rsp_addr_ff;

   assign fit       = mem_q.free && (SW'(mem_q.size) >= SW'(size_ff));
   assign better    = !found_ff || (mem_q.size < hit_ent_ff.size);
   assign match_sum = SW'(mem_q.start) + SW'(HEADER_BYTES);
   assign match     = (match_sum == SW'(faddr_ff));
   assign scan_end  = (issue_ff == count_ff) && !p_valid_ff;
   // Split only when the leftover exceeds one header plus the slack.
   assign split_cond = (XW'(hit_ent_ff.size) >
                        (XW'(size_ff) + XW'(HEADER_BYTES) + XW'(SPLIT_SLACK)))
                       && (count_ff < CW'(MAX_BLOCKS));
   assign best_pay  = SW'(hit_ent_ff.start) + SW'(HEADER_BYTES);
   assign nf_w      = has_next_ff && next_ff.free;
   assign pf_w      = has_prev_ff && prev_ff.free;
   assign tot_k     = nf_ff ? (hit_ent_ff.size + W'(HEADER_BYTES) + next_ff.size)
                            : hit_ent_ff.size;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      op_free_in    = op_free_ff;
      size_in       = size_ff;
      faddr_in      = faddr_ff;
      issue_in      = issue_ff;
      p_valid_in    = 1'b0;
      p_idx_in      = p_idx_ff;
      found_in      = found_ff;
      hit_in        = hit_ff;
      hit_ent_in    = hit_ent_ff;
      prev_in       = prev_ff;
      next_in       = next_ff;
      last_in       = last_ff;
      has_prev_in   = has_prev_ff;
      has_next_in   = has_next_ff;
      split_in      = split_ff;
      pf_in         = pf_ff;
      nf_in         = nf_ff;
      sh_up_in      = sh_up_ff;
      sh_d_in       = sh_d_ff;
      sh_rd_in      = sh_rd_ff;
      sh_left_in    = sh_left_ff;
      res_st_in     = res_st_ff;
      res_addr_in   = res_addr_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      mem_re        = 1'b0;
      mem_ra        = issue_ff[IW-1:0];
      mem_we        = 1'b0;
      mem_wa        = '0;
      mem_wd        = '0;

      unique case (state_ff)
         S_INIT: begin
            // The single free block that covers the heap minus one header.
            mem_we       = 1'b1;
            mem_wa       = '0;
            mem_wd.start = '0;
            mem_wd.size  = W'(HEAP_BYTES - HEADER_BYTES);
            mem_wd.free  = 1'b1;
            state_in     = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               op_free_in  = (req_type == REQ_FREE);
               size_in     = req_size;
               faddr_in    = req_free_addr;
               issue_in    = '0;
               found_in    = 1'b0;
               has_next_in = 1'b0;
               has_prev_in = 1'b0;
               res_addr_in = '0;
               res_st_in   = ST_OK;
               if ((req_type == REQ_FREE) && req_null_pointer) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (issue_ff != count_ff) begin
               mem_re     = 1'b1;
               mem_ra     = issue_ff[IW-1:0];
               issue_in   = issue_ff + CW'(1);
               p_valid_in = 1'b1;
               p_idx_in   = issue_ff;
            end
            if (p_valid_ff) begin
               last_in = mem_q;
               if (!op_free_ff) begin
                  if (fit && better) begin
                     found_in   = 1'b1;
                     hit_in     = p_idx_ff;
                     hit_ent_in = mem_q;
                  end
               end else begin
                  if (!found_ff && match) begin
                     found_in    = 1'b1;
                     hit_in      = p_idx_ff;
                     hit_ent_in  = mem_q;
                     prev_in     = last_ff;
                     has_prev_in = (p_idx_ff != '0);
                  end
                  if (found_ff && (p_idx_ff == hit_ff + CW'(1))) begin
                     next_in     = mem_q;
                     has_next_in = 1'b1;
                  end
               end
            end
            if (scan_end) begin
               if (!found_ff) begin
                  res_st_in = op_free_ff ? ST_BAD_ADDR : ST_NO_FIT;
                  state_in  = S_DONE;
               end else if (!op_free_ff) begin
                  res_addr_in = best_pay[ADDR_BITS-1:0];
                  split_in    = split_cond;
                  if (split_cond) begin
                     // Open a hole at hit+1 by moving the tail up one place.
                     sh_up_in   = 1'b1;
                     sh_rd_in   = count_ff - CW'(1);
                     sh_left_in = count_ff - CW'(1) - hit_ff;
                     count_in   = count_ff + CW'(1);
                     state_in   = S_SHIFT;
                  end else begin
                     state_in   = S_WR_A;
                  end
               end else begin
                  nf_in    = nf_w;
                  pf_in    = pf_w;
                  sh_up_in = 1'b0;
                  sh_d_in  = (nf_w && pf_w) ? 2'd2 : 2'd1;
                  if (pf_w && !nf_w) begin
                     sh_rd_in   = hit_ff + CW'(1);
                     sh_left_in = count_ff - CW'(1) - hit_ff;
                  end else begin
                     sh_rd_in   = hit_ff + CW'(2);
                     sh_left_in = (nf_w || pf_w) ? (count_ff - CW'(2) - hit_ff) : '0;
                  end
                  count_in = count_ff - CW'(nf_w) - CW'(pf_w);
                  state_in = S_WR_A;
               end
            end
         end
         S_SHIFT: begin
            if (sh_left_ff != '0) begin
               mem_re     = 1'b1;
               mem_ra     = sh_rd_ff[IW-1:0];
               p_valid_in = 1'b1;
               p_idx_in   = sh_rd_ff;
               sh_left_in = sh_left_ff - CW'(1);
               sh_rd_in   = sh_up_ff ? (sh_rd_ff - CW'(1)) : (sh_rd_ff + CW'(1));
            end
            if (p_valid_ff) begin
               mem_we = 1'b1;
               mem_wd = mem_q;
               if (sh_up_ff) begin
                  mem_wa = IW'(p_idx_ff + CW'(1));
               end else begin
                  mem_wa = IW'(p_idx_ff - CW'(sh_d_ff));
               end
            end
            if ((sh_left_ff == '0) && !p_valid_ff) begin
               state_in = op_free_ff ? S_DONE : S_WR_A;
            end
         end
         S_WR_A: begin
            mem_we = 1'b1;
            if (!op_free_ff) begin
               mem_wa       = hit_ff[IW-1:0];
               mem_wd.start = hit_ent_ff.start;
               mem_wd.size  = split_ff ? W'(size_ff) : hit_ent_ff.size;
               mem_wd.free  = 1'b0;
               state_in     = split_ff ? S_WR_B : S_DONE;
            end else begin
               // Merged block lands on the previous entry when that one is free.
               if (pf_ff) begin
                  mem_wa       = IW'(hit_ff - CW'(1));
                  mem_wd.start = prev_ff.start;
                  mem_wd.size  = prev_ff.size + W'(HEADER_BYTES) + tot_k;
               end else begin
                  mem_wa       = hit_ff[IW-1:0];
                  mem_wd.start = hit_ent_ff.start;
                  mem_wd.size  = tot_k;
               end
               mem_wd.free = 1'b1;
               state_in    = S_SHIFT;
            end
         end
         S_WR_B: begin
            // Remainder of the split becomes a new free block right after it.
            mem_we       = 1'b1;
            mem_wa       = IW'(hit_ff + CW'(1));
            mem_wd.start = hit_ent_ff.start + W'(HEADER_BYTES) + W'(size_ff);
            mem_wd.size  = hit_ent_ff.size - W'(size_ff) - W'(HEADER_BYTES);
            mem_wd.free  = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_st_ff;
               rsp_addr_in   = (res_st_ff == ST_OK) ? res_addr_ff : '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         count_ff     <= CW'(1);
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_free_ff    <= op_free_in;
      size_ff       <= size_in;
      faddr_ff      <= faddr_in;
      issue_ff      <= issue_in;
      p_idx_ff      <= p_idx_in;
      found_ff      <= found_in;
      hit_ff        <= hit_in;
      hit_ent_ff    <= hit_ent_in;
      prev_ff       <= prev_in;
      next_ff       <= next_in;
      last_ff       <= last_in;
      has_prev_ff   <= has_prev_in;
      has_next_ff   <= has_next_in;
      split_ff      <= split_in;
      pf_ff         <= pf_in;
      nf_ff         <= nf_in;
      sh_up_ff      <= sh_up_in;
      sh_d_ff       <= sh_d_in;
      sh_rd_ff      <= sh_rd_in;
      sh_left_ff    <= sh_left_in;
      res_st_ff     <= res_st_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

endmodule
